// ===== rtl/core/caf_pkg.sv =====
// Shared types, constants and helpers for the CAN acceptance filter.
// No dependencies; every other file of the block but caf_ram imports this package.
`default_nettype none

package caf_pkg;

    // Table geometry and frame limits
    localparam int FILTER_DEPTH  = 128;
    localparam int PAYLOAD_LIMIT = 64;
    localparam int TBL_AW        = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
    localparam int CNT_W         = $clog2(FILTER_DEPTH + 1);
    localparam int ENTRY_W       = 64;

    // Fixed field widths
    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 7;
    localparam int ID_W     = 32;
    localparam int LEN_W    = 8;
    localparam int VER_W    = 16;
    localparam int OP_W     = 16;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 8;

    // Configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // Frame id flag bits and the id fields they allow
    localparam logic [ID_W-1:0] ALLOWED_EXT = 32'hFFFF_FFFF;
    localparam logic [ID_W-1:0] ALLOWED_STD = 32'hE000_07FF;

    typedef enum logic [1:0] {
        REG_COUNT   = 2'd0,
        REG_MAGIC   = 2'd1,
        REG_VERSION = 2'd2,
        REG_OPCODE  = 2'd3
    } t_reg;

    typedef enum logic [KIND_W-1:0] {
        KIND_WRITE = 2'd0,
        KIND_RX    = 2'd1,
        KIND_TX    = 2'd2
    } t_kind;

    typedef enum logic [STATUS_W-1:0] {
        ST_ACCEPT   = 3'd0,
        ST_HEADER   = 3'd1,
        ST_INVALID  = 3'd2,
        ST_FILTERED = 3'd3,
        ST_WRITTEN  = 3'd4
    } t_status;

    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic [ID_W-1:0]    magic;
        logic [VER_W-1:0]   version;
        logic [OP_W-1:0]    opcode;
    } t_cfg;

    // Length within payload limit and no id bits outside flags and id field
    function automatic logic frame_ok(input logic [ID_W-1:0] id, input logic [LEN_W-1:0] len);
        logic [ID_W-1:0] allowed;
        allowed  = id[31] ? ALLOWED_EXT : ALLOWED_STD;
        frame_ok = (32'(len) <= 32'(PAYLOAD_LIMIT)) && ((id & ~allowed) == '0);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/caf_if.sv =====
// Valid/ready channel interfaces for the filter's item and result beats.
// Depends on caf_pkg for field widths.
`default_nettype none

interface caf_in_if;
    import caf_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] entry_index;
    logic [ID_W-1:0]    entry_id;
    logic [ID_W-1:0]    entry_mask;
    logic [ID_W-1:0]    frame_id;
    logic [LEN_W-1:0]   frame_len;
    logic [ID_W-1:0]    header_magic;
    logic [VER_W-1:0]   header_version;
    logic [OP_W-1:0]    header_opcode;
    logic               full_size;

    modport source (
        output valid, kind, entry_index, entry_id, entry_mask, frame_id, frame_len,
               header_magic, header_version, header_opcode, full_size,
        input  ready
    );
    modport sink (
        input  valid, kind, entry_index, entry_id, entry_mask, frame_id, frame_len,
               header_magic, header_version, header_opcode, full_size,
        output ready
    );
endinterface

interface caf_out_if;
    import caf_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     passed_id;

    modport source (output valid, status, passed_id, input ready);
    modport sink   (input valid, status, passed_id, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/caf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module caf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 128
) (
    input  wire                                      i_clk,
    input  wire                                      i_wr_en,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire  [WIDTH-1:0]                         i_wr_data,
    input  wire                                      i_rd_en,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule

`default_nettype wire

// ===== rtl/core/caf_cfg.sv =====
// APB-style configuration registers of the acceptance filter.
// Depends on caf_pkg for the register map and the t_cfg struct.
`default_nettype none

module caf_cfg (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [caf_pkg::PADDR_W-1:0]   paddr,
    input  wire  [caf_pkg::PDATA_W-1:0]   pwdata,
    output logic [caf_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output caf_pkg::t_cfg                 o_cfg
);
    import caf_pkg::*;

    t_cfg r_cfg;
    t_reg w_reg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_reg  = t_reg'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;
    assign o_cfg  = r_cfg;

    // Update the addressed register on the access beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            case (w_reg)
                REG_COUNT:   r_cfg.count   <= pwdata[COUNT_W-1:0];
                REG_MAGIC:   r_cfg.magic   <= pwdata[ID_W-1:0];
                REG_VERSION: r_cfg.version <= pwdata[VER_W-1:0];
                REG_OPCODE:  r_cfg.opcode  <= pwdata[OP_W-1:0];
                default:     r_cfg         <= r_cfg;
            endcase
        end
    end

    // Read back the addressed register
    always_comb begin
        case (w_reg)
            REG_COUNT:   prdata = PDATA_W'(r_cfg.count);
            REG_MAGIC:   prdata = PDATA_W'(r_cfg.magic);
            REG_VERSION: prdata = PDATA_W'(r_cfg.version);
            REG_OPCODE:  prdata = PDATA_W'(r_cfg.opcode);
            default:     prdata = '0;
        endcase
    end
endmodule

`default_nettype wire

// ===== rtl/core/caf_engine.sv =====
// Item sequencer: header and validity checks, table writes, and the scan
// of the id/mask table held in caf_ram. Depends on caf_pkg, caf_if, caf_ram.
`default_nettype none

module caf_engine (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  caf_pkg::t_cfg  i_cfg,
    caf_in_if.sink         i_in,
    caf_out_if.source      o_out
);
    import caf_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_POST
    } t_state;

    t_state              r_state;
    logic [ID_W-1:0]     r_fid;
    t_status             r_res_status;
    logic [ID_W-1:0]     r_res_pid;
    logic [CNT_W-1:0]    r_issue;
    logic [CNT_W-1:0]    r_lim;
    logic                r_chk;
    logic                r_chk_last;
    logic                r_out_valid;
    t_status             r_out_status;
    logic [ID_W-1:0]     r_out_pid;

    logic                w_accept;
    t_kind               w_kind;
    logic                w_hdr_ok;
    logic                w_frame_ok;
    logic [CNT_W-1:0]    w_lim;
    logic                w_wr_en;
    logic                w_rd_en;
    logic [CNT_W-1:0]    w_issue_next;
    logic [ENTRY_W-1:0]  w_rd_data;
    logic                w_hit;

    assign i_in.ready      = (r_state == S_IDLE);
    assign o_out.valid     = r_out_valid;
    assign o_out.status    = r_out_status;
    assign o_out.passed_id = r_out_pid;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_kind     = t_kind'(i_in.kind);
    assign w_hdr_ok   = i_in.full_size && (i_in.header_magic == i_cfg.magic) &&
                        (i_in.header_version == i_cfg.version) &&
                        (i_in.header_opcode == i_cfg.opcode);
    assign w_frame_ok = frame_ok(i_in.frame_id, i_in.frame_len);

    // Clamp the active count to the table depth
    assign w_lim = (32'(i_cfg.count) > 32'(FILTER_DEPTH)) ? CNT_W'(FILTER_DEPTH)
                                                           : CNT_W'(i_cfg.count);

    // Table writes happen only on an accepted beat in idle, never during a scan
    assign w_wr_en = w_accept && (w_kind == KIND_WRITE) &&
                     (32'(i_in.entry_index) < 32'(FILTER_DEPTH));
    assign w_rd_en = (r_state == S_SCAN) && (r_issue < r_lim);
    assign w_issue_next = r_issue + CNT_W'(1);

    // Entry layout is {mask, id}
    assign w_hit = ((r_fid ^ w_rd_data[ID_W-1:0]) & w_rd_data[ENTRY_W-1:ID_W]) == '0;

    caf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (FILTER_DEPTH)
    ) u_tbl (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (TBL_AW'(i_in.entry_index)),
        .i_wr_data ({i_in.entry_mask, i_in.entry_id}),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_issue[TBL_AW-1:0]),
        .o_rd_data (w_rd_data)
    );

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_chk       <= 1'b0;
            r_chk_last  <= 1'b0;
            r_issue     <= '0;
        end else begin
            // Drop the result once taken, unless the next one loads now
            if (r_out_valid && o_out.ready && (r_state != S_POST)) begin
                r_out_valid <= 1'b0;
            end
            r_chk      <= w_rd_en;
            r_chk_last <= (w_issue_next == r_lim);

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_fid     <= i_in.frame_id;
                        r_issue   <= '0;
                        r_lim     <= w_lim;
                        case (w_kind)
                            KIND_WRITE: begin
                                r_res_status <= ST_WRITTEN;
                                r_res_pid    <= '0;
                                r_state      <= S_POST;
                            end
                            KIND_RX: begin
                                if (!w_hdr_ok) begin
                                    r_res_status <= ST_HEADER;
                                    r_res_pid    <= '0;
                                    r_state      <= S_POST;
                                end else if (!w_frame_ok) begin
                                    r_res_status <= ST_INVALID;
                                    r_res_pid    <= '0;
                                    r_state      <= S_POST;
                                end else if (w_lim == '0) begin
                                    r_res_status <= ST_ACCEPT;
                                    r_res_pid    <= i_in.frame_id;
                                    r_state      <= S_POST;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            KIND_TX: begin
                                r_res_status <= w_frame_ok ? ST_ACCEPT : ST_INVALID;
                                r_res_pid    <= w_frame_ok ? i_in.frame_id : '0;
                                r_state      <= S_POST;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SCAN: begin
                    // Advance the read pointer, check each entry in the cycle after its read
                    if (w_rd_en) begin
                        r_issue <= w_issue_next;
                    end
                    if (r_chk && w_hit) begin
                        r_res_status <= ST_ACCEPT;
                        r_res_pid    <= r_fid;
                        r_state      <= S_POST;
                    end else if (r_chk && r_chk_last) begin
                        r_res_status <= ST_FILTERED;
                        r_res_pid    <= '0;
                        r_state      <= S_POST;
                    end
                end
                S_POST: begin
                    // Hold until the output register is free
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_status <= r_res_status;
                        r_out_pid    <= r_res_pid;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_wr_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_state == S_IDLE))
        else $error("table written outside idle");

    a_pid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_ACCEPT)) |-> (r_out_pid == '0))
        else $error("nonzero id on a rejected result");

    a_chk_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_chk |-> ($past(r_state) == S_SCAN))
        else $error("entry check outside a scan");

    a_issue_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_issue <= r_lim))
        else $error("read pointer beyond active count");
`endif
endmodule

`default_nettype wire

// ===== rtl/core/can_acceptance_filter_top.sv =====
// Top level of the CAN acceptance filter: configuration registers and the
// item sequencer. Depends on caf_pkg, caf_if, caf_cfg, caf_engine.
//
//  channel   dir  handshake            beat contents
//  i_in      in   valid/ready          kind, entry fields, frame fields, header
//  o_out     out  valid/ready          status, passed_id
//  apb       in   psel/penable/pready  paddr, pwdata, prdata
//
// One item at a time. A result moves through S_POST into the output register
// after its item is accepted, and S_POST waits while an untaken result holds
// the output register; a received frame that walks the table first scans the
// active entries (capped at the table depth) in S_SCAN, one table read per entry
// from the single RAM port, and ends early at the first matching entry.
// A kind 3 beat is accepted and gives no result.
// Reset is synchronous, active low; the table contents are not cleared.
// A result waiting in the output register does not stop the next beat.
`default_nettype none

module can_acceptance_filter_top (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    caf_in_if.sink                       i_in,
    caf_out_if.source                    o_out,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [caf_pkg::PADDR_W-1:0]  paddr,
    input  wire  [caf_pkg::PDATA_W-1:0]  pwdata,
    output logic [caf_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready
);
    import caf_pkg::*;

    t_cfg w_cfg;

    caf_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    caf_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_in    (i_in),
        .o_out   (o_out)
    );
endmodule

`default_nettype wire

// ===== tb/tb_can_acceptance_filter_top.sv =====
// Self-checking bench for can_acceptance_filter_top: drives item beats and APB
// register writes, predicts each result and checks it. Depends on caf_pkg, caf_if and the top.
`timescale 1ns / 100ps

module tb_can_acceptance_filter_top;
    import caf_pkg::*;

    localparam int CLK_NS       = 12;
    localparam int LAT_GUARD    = FILTER_DEPTH + 8;
    localparam int LIMIT_CYCLES = 600_000;
    localparam int PHASES       = 10;
    localparam int PHASE_BEATS  = 70;
    localparam int HOLD_CYCLES  = 300;

    // Kind code that the block accepts and drops
    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [INDEX_W-1:0] entry_index;
        logic [ID_W-1:0]    entry_id;
        logic [ID_W-1:0]    entry_mask;
        logic [ID_W-1:0]    frame_id;
        logic [LEN_W-1:0]   frame_len;
        logic [ID_W-1:0]    header_magic;
        logic [VER_W-1:0]   header_version;
        logic [OP_W-1:0]    header_opcode;
        logic               full_size;
    } t_filter_beat;

    typedef struct {
        t_status         status;
        logic [ID_W-1:0] passed_id;
    } t_verdict;

    // Mirror of the filter state; turns input beats into awaited verdicts
    class t_verdict_board;
        logic [ID_W-1:0]    slot_id   [FILTER_DEPTH];
        logic [ID_W-1:0]    slot_mask [FILTER_DEPTH];
        logic [COUNT_W-1:0] active_count;
        logic [ID_W-1:0]    magic;
        logic [VER_W-1:0]   version;
        logic [OP_W-1:0]    opcode;
        t_verdict           awaited [$];
        int unsigned        faults;

        function new();
            foreach (slot_id[i]) begin
                slot_id[i]   = '0;
                slot_mask[i] = '0;
            end
            active_count = '0;
            magic        = '0;
            version      = '0;
            opcode       = '0;
            faults       = 0;
        endfunction

        function void set_reg(t_reg r, logic [PDATA_W-1:0] v);
            case (r)
                REG_COUNT:   active_count = v[COUNT_W-1:0];
                REG_MAGIC:   magic        = v;
                REG_VERSION: version      = v[VER_W-1:0];
                REG_OPCODE:  opcode       = v[OP_W-1:0];
                default: ;
            endcase
        endfunction

        // Length within limit, no id bits outside the flags and the id field
        function bit frame_well_formed(logic [ID_W-1:0] id, logic [LEN_W-1:0] len);
            logic [ID_W-1:0] allowed;
            allowed = id[31] ? ALLOWED_EXT : ALLOWED_STD;
            return (int'(len) <= PAYLOAD_LIMIT) && ((id & ~allowed) == '0);
        endfunction

        // Walk the active slots; an empty set lets everything through
        function bit table_hit(logic [ID_W-1:0] id);
            int n;
            n = int'(active_count);
            if (n == 0)
                return 1'b1;
            if (n > FILTER_DEPTH)
                n = FILTER_DEPTH;
            for (int i = 0; i < n; i++) begin
                if ((id & slot_mask[i]) == (slot_id[i] & slot_mask[i]))
                    return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_beat(t_filter_beat b);
            t_verdict v;
            v.passed_id = '0;
            case (b.kind)
                KIND_WRITE: begin
                    slot_id[b.entry_index]   = b.entry_id;
                    slot_mask[b.entry_index] = b.entry_mask;
                    v.status = ST_WRITTEN;
                end
                KIND_RX: begin
                    if (!b.full_size || b.header_magic != magic ||
                        b.header_version != version || b.header_opcode != opcode)
                        v.status = ST_HEADER;
                    else if (!frame_well_formed(b.frame_id, b.frame_len))
                        v.status = ST_INVALID;
                    else if (!table_hit(b.frame_id))
                        v.status = ST_FILTERED;
                    else begin
                        v.status    = ST_ACCEPT;
                        v.passed_id = b.frame_id;
                    end
                end
                KIND_TX: begin
                    if (!frame_well_formed(b.frame_id, b.frame_len))
                        v.status = ST_INVALID;
                    else begin
                        v.status    = ST_ACCEPT;
                        v.passed_id = b.frame_id;
                    end
                end
                default: return;
            endcase
            awaited.push_back(v);
        endfunction

        function void check_verdict(logic [STATUS_W-1:0] st, logic [ID_W-1:0] pid);
            t_verdict v;
            if (awaited.size() == 0) begin
                faults++;
                $display("%0t: unexpected result beat, expected none, actual status %0d id %h",
                         $time, st, pid);
                return;
            end
            v = awaited.pop_front();
            if (st !== v.status) begin
                faults++;
                $display("%0t: status mismatch, expected %0d, actual %0d",
                         $time, v.status, st);
            end
            if (pid !== v.passed_id) begin
                faults++;
                $display("%0t: passed_id mismatch, expected %h, actual %h",
                         $time, v.passed_id, pid);
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    caf_in_if  in_ch ();
    caf_out_if out_ch ();

    t_verdict_board board = new();

    // Run-shaping flags shared by the sender and the receiver
    bit tail_calm;
    int hold_req;

    can_acceptance_filter_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_NS / 2) i_clk = ~i_clk;
    end

    initial begin
        #(CLK_NS * LIMIT_CYCLES);
        $display("DONE: errors detected");
        $finish;
    end

    // Check every result beat the bench takes
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready)
            board.check_verdict(out_ch.status, out_ch.passed_id);
    end

    // Drive ready: random stall bursts, long holds on request, none in the tail
    initial begin
        int  stall_left;
        int  hold_left;
        int  ticks;
        bit  rx_idling;
        stall_left   = 0;
        hold_left    = 0;
        ticks        = 0;
        rx_idling    = 1'b1;
        out_ch.ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            ticks++;
            if (ticks % 64 == 0)
                rx_idling = ($urandom_range(2) != 0);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready = 1'b0;
            end else if (!tail_calm && rx_idling && $urandom_range(4) == 0) begin
                stall_left   = $urandom_range(1, 7) - 1;
                out_ch.ready = 1'b0;
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    // Offer one beat and hold it until the block takes it
    task automatic send_beat(t_filter_beat b);
        @(negedge i_clk);
        in_ch.valid          = 1'b1;
        in_ch.kind           = b.kind;
        in_ch.entry_index    = b.entry_index;
        in_ch.entry_id       = b.entry_id;
        in_ch.entry_mask     = b.entry_mask;
        in_ch.frame_id       = b.frame_id;
        in_ch.frame_len      = b.frame_len;
        in_ch.header_magic   = b.header_magic;
        in_ch.header_version = b.header_version;
        in_ch.header_opcode  = b.header_opcode;
        in_ch.full_size      = b.full_size;
        @(posedge i_clk);
        while (!in_ch.ready)
            @(posedge i_clk);
        board.note_beat(b);
    endtask

    // Drop valid for a number of cycles
    task automatic rest_sender(int cycles);
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        repeat (cycles - 1) @(negedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic write_reg(t_reg r, logic [PDATA_W-1:0] v);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {r, 2'b00};
        pwdata  = v;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        board.set_reg(r, v);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Wait for every awaited result, then for a possible dropped beat to clear
    task automatic drain_results();
        while (board.awaited.size() != 0)
            @(posedge i_clk);
        repeat (LAT_GUARD) @(posedge i_clk);
    endtask

    // Random id shaped as standard with flags, extended, bare standard or raw
    function automatic logic [ID_W-1:0] shaped_id();
        logic [ID_W-1:0] v;
        v = $urandom;
        case ($urandom_range(3))
            0: v = v & ALLOWED_STD;
            1: v[31] = 1'b1;
            2: v = v & 32'h0000_07FF;
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [ID_W-1:0] pick_mask(bit may_clear);
        case ($urandom_range(7))
            0: return 32'hFFFF_FFFF;
            1: return 32'h0000_07FF;
            2: return 32'h1FFF_FFFF;
            3: return ALLOWED_STD;
            4: return $urandom;
            5: return $urandom & $urandom & $urandom;
            6: return (may_clear && $urandom_range(3) == 0) ? 32'h0 : 32'h0000_07F0;
            default: return 32'h1FFF_FF00;
        endcase
    endfunction

    // Beat with a clean header for the reset register values
    function automatic t_filter_beat plain_beat(logic [KIND_W-1:0] k, logic [ID_W-1:0] fid,
                                                logic [LEN_W-1:0] len);
        t_filter_beat b;
        b.kind           = k;
        b.entry_index    = INDEX_W'($urandom);
        b.entry_id       = $urandom;
        b.entry_mask     = $urandom;
        b.frame_id       = fid;
        b.frame_len      = len;
        b.header_magic   = '0;
        b.header_version = '0;
        b.header_opcode  = '0;
        b.full_size      = 1'b1;
        return b;
    endfunction

    // Mostly well-formed received frames aimed at active slots, plus noise
    function automatic t_filter_beat random_beat();
        t_filter_beat b;
        int roll;
        int span;
        int e;
        b.kind           = KIND_RX;
        b.entry_index    = INDEX_W'($urandom);
        b.entry_id       = $urandom;
        b.entry_mask     = $urandom;
        b.frame_id       = $urandom;
        b.frame_len      = LEN_W'($urandom);
        b.header_magic   = $urandom;
        b.header_version = VER_W'($urandom);
        b.header_opcode  = OP_W'($urandom);
        b.full_size      = 1'($urandom);
        roll = $urandom_range(99);
        if (roll < 8) begin
            b.kind       = KIND_WRITE;
            b.entry_id   = shaped_id();
            b.entry_mask = pick_mask(1'b1);
        end else if (roll < 12) begin
            b.kind = KIND_SPARE;
        end else begin
            b.kind = (roll < 22) ? KIND_TX : KIND_RX;
            if ($urandom_range(9) < 6) begin
                span = (board.active_count == 0 || board.active_count > FILTER_DEPTH)
                       ? FILTER_DEPTH : int'(board.active_count);
                e = $urandom_range(span - 1);
                b.frame_id = (board.slot_id[e] & board.slot_mask[e]) |
                             (shaped_id() & ~board.slot_mask[e]);
            end else begin
                b.frame_id = shaped_id();
            end
            if ($urandom_range(9) < 8)
                b.frame_len = LEN_W'($urandom_range(PAYLOAD_LIMIT));
            if (b.kind == KIND_RX && $urandom_range(99) < 85) begin
                b.header_magic   = board.magic;
                b.header_version = board.version;
                b.header_opcode  = board.opcode;
                b.full_size      = 1'b1;
                // spoil one header field now and then
                case ($urandom_range(19))
                    0: b.full_size = 1'b0;
                    1: b.header_magic   ^= 32'd1 << $urandom_range(31);
                    2: b.header_version ^= 16'd1 << $urandom_range(15);
                    3: b.header_opcode  ^= 16'd1 << $urandom_range(15);
                    default: ;
                endcase
            end
        end
        return b;
    endfunction

    initial begin
        t_filter_beat b;
        logic [COUNT_W-1:0] cnt;
        logic [ID_W-1:0]    mgc;
        logic [VER_W-1:0]   ver;
        logic [OP_W-1:0]    opc;
        bit                 tx_idling;

        i_rst_n   = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        tail_calm = 1'b0;
        hold_req  = 0;
        tx_idling = 1'b1;
        in_ch.valid          = 1'b0;
        in_ch.kind           = '0;
        in_ch.entry_index    = '0;
        in_ch.entry_id       = '0;
        in_ch.entry_mask     = '0;
        in_ch.frame_id       = '0;
        in_ch.frame_len      = '0;
        in_ch.header_magic   = '0;
        in_ch.header_version = '0;
        in_ch.header_opcode  = '0;
        in_ch.full_size      = 1'b0;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed beats at reset register values: empty filter set passes all
        send_beat(plain_beat(KIND_SPARE, 32'h0, 8'd0));
        b = plain_beat(KIND_WRITE, 32'h0, 8'd0);
        b.entry_index = 7'd0;
        b.entry_id    = 32'h0000_0123;
        b.entry_mask  = 32'h0000_07FF;
        send_beat(b);
        b = plain_beat(KIND_WRITE, 32'h0, 8'd0);
        b.entry_index = 7'd127;
        b.entry_id    = 32'hFFFF_FFFF;
        b.entry_mask  = 32'hFFFF_FFFF;
        send_beat(b);
        send_beat(plain_beat(KIND_RX, 32'h0000_07FF, 8'd64));
        send_beat(plain_beat(KIND_RX, 32'h0000_0800, 8'd8));
        send_beat(plain_beat(KIND_RX, 32'h0000_0123, 8'd65));
        send_beat(plain_beat(KIND_RX, 32'h0000_0123, 8'd255));
        send_beat(plain_beat(KIND_RX, 32'h0000_0000, 8'd0));
        send_beat(plain_beat(KIND_RX, 32'hFFFF_FFFF, 8'd8));
        send_beat(plain_beat(KIND_RX, 32'h6000_07FF, 8'd8));
        send_beat(plain_beat(KIND_RX, 32'h7FFF_FFFF, 8'd8));
        b = plain_beat(KIND_RX, 32'h0000_0001, 8'd1);
        b.full_size = 1'b0;
        send_beat(b);
        b = plain_beat(KIND_RX, 32'h0000_0001, 8'd1);
        b.header_magic = 32'hFFFF_FFFF;
        send_beat(b);
        b = plain_beat(KIND_RX, 32'h0000_0001, 8'd1);
        b.header_version = 16'hFFFF;
        send_beat(b);
        b = plain_beat(KIND_RX, 32'h0000_0001, 8'd255);
        b.header_opcode = 16'hFFFF;
        send_beat(b);
        send_beat(plain_beat(KIND_TX, 32'h0000_0800, 8'd0));
        b = plain_beat(KIND_TX, 32'h9FFF_FFFF, 8'd64);
        b.header_magic = 32'hDEAD_0001;
        b.full_size    = 1'b0;
        send_beat(b);
        send_beat(plain_beat(KIND_TX, 32'h0000_0010, 8'd65));
        rest_sender(1);
        drain_results();

        // Fill every slot so any filter count only reads written entries
        for (int i = 0; i < FILTER_DEPTH; i++) begin
            b = plain_beat(KIND_WRITE, $urandom, LEN_W'($urandom));
            b.entry_index = INDEX_W'(i);
            b.entry_id    = shaped_id();
            b.entry_mask  = pick_mask(1'b0);
            send_beat(b);
            if ($urandom_range(5) == 0)
                rest_sender($urandom_range(1, 7));
        end
        rest_sender(1);
        drain_results();

        // Random phases, each with its own register setting
        for (int ph = 0; ph < PHASES; ph++) begin
            mgc = $urandom;
            ver = VER_W'($urandom);
            opc = OP_W'($urandom);
            case (ph)
                0: cnt = 8'd1;
                1: begin
                    cnt = 8'd128;
                    mgc = 32'hFFFF_FFFF;
                    ver = 16'hFFFF;
                    opc = 16'hFFFF;
                end
                2: cnt = 8'd255;
                3: begin
                    cnt = 8'd0;
                    mgc = '0;
                    ver = '0;
                    opc = '0;
                end
                4: cnt = 8'd129;
                default: cnt = COUNT_W'($urandom_range(2, 127));
            endcase
            write_reg(REG_COUNT, PDATA_W'(cnt));
            write_reg(REG_MAGIC, mgc);
            write_reg(REG_VERSION, PDATA_W'(ver));
            write_reg(REG_OPCODE, PDATA_W'(opc));
            tail_calm = (ph == PHASES - 1);

            for (int k = 0; k < PHASE_BEATS; k++) begin
                // long receiver hold while beats keep coming back to back
                if (ph == 5 && k == 10)
                    hold_req = HOLD_CYCLES;
                if (k % 25 == 0)
                    tx_idling = ($urandom_range(2) != 0);
                send_beat(random_beat());
                if (!tail_calm && tx_idling && !(ph == 5 && k >= 10 && k < 30) &&
                    $urandom_range(3) == 0)
                    rest_sender($urandom_range(1, 7));
            end
            rest_sender(1);
            drain_results();
        end

        if (board.faults == 0 && board.awaited.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/caf_pkg.sv
rtl/core/caf_if.sv
rtl/core/caf_ram.sv
rtl/core/caf_cfg.sv
rtl/core/caf_engine.sv
rtl/core/can_acceptance_filter_top.sv
tb/tb_can_acceptance_filter_top.sv
